// File: sv/lqa_pkg.sv
// ============================================================================
// lqa_pkg
// Shared types and constants for the longest-queue arbiter with overload
// admission control.
// ============================================================================
package lqa_pkg;

    // Geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 4;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH   = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int TOT_W       = $clog2(MEM_DEPTH + 1);

    // Field widths
    localparam int QSEL_W  = 2;
    localparam int ID_W    = 16;
    localparam int LEN_W   = 10;
    localparam int SVC_W   = 12;
    localparam int TOTO_W  = 7;
    localparam int LIM_W   = 7;
    localparam int SPD_W   = 10;
    localparam int PEN_W   = 4;
    localparam int EV_W    = 3;
    localparam int ENTRY_W = ID_W + LEN_W;
    localparam int SUM_W   = LEN_W + 1;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS = SUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    // Stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // Register reset values
    localparam logic [LIM_W-1:0] LIMIT_RST   = LIM_W'(10);
    localparam logic [LEN_W-1:0] PATH_RST    = LEN_W'(100);
    localparam logic [SPD_W-1:0] SPEED_RST   = SPD_W'(100);
    localparam logic [PEN_W-1:0] PENALTY_RST = PEN_W'(4);
    localparam logic [SVC_W-1:0] SVC_MAX     = '1;

    typedef enum logic [EV_W-1:0] {
        EV_ADMIT   = 3'd0,
        EV_REFUSED = 3'd1,
        EV_ENTER   = 3'd2,
        EV_CLEAR   = 3'd3,
        EV_FULL    = 3'd4,
        EV_GRANT   = 3'd5,
        EV_EMPTY   = 3'd6
    } t_event;

    typedef enum logic {
        ACT_ARRIVE = 1'b0,
        ACT_SERVE  = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT   = 2'd0,
        CFG_PATH    = 2'd1,
        CFG_SPEED   = 2'd2,
        CFG_PENALTY = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DIV,
        S_FIN,
        S_HOLD
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic rd_take;
        logic div_step;
        logic finish;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic to_grant;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// File: sv/lqa_ctrl.sv
// ============================================================================
// lqa_ctrl
// Sequencer: accept, decide, then for a grant fetch head entry, divide and finish, hand off.
// ============================================================================
module lqa_ctrl
    import lqa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_status.to_grant ? S_READ : S_HOLD;
            end
            S_READ: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) n_state = S_FIN;
            end
            S_FIN:  n_state = S_HOLD;
            S_HOLD: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: o_cmd.exec     = 1'b1;
            S_READ: o_cmd.rd_take  = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_FIN:  o_cmd.finish   = 1'b1;
            S_HOLD: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: sv/lqa_dp.sv
// ============================================================================
// lqa_dp
// Datapath: queue pointers and counts, entry memory, admission logic,
// longest-queue selection, serial divider and output register.
// ============================================================================
module lqa_dp
    import lqa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    // latched input item
    input  t_action            i_action,
    input  logic [QSEL_W-1:0]  i_sel,
    input  logic [LEN_W-1:0]   i_len,
    input  logic               i_fault,
    // configuration
    input  logic [LIM_W-1:0]   i_limit,
    input  logic [LEN_W-1:0]   i_path,
    input  logic [SPD_W-1:0]   i_speed,
    input  logic [PEN_W-1:0]   i_penalty,
    // result
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_event             o_ev,
    output logic [QSEL_W-1:0]  o_gq,
    output logic [ID_W-1:0]    o_id,
    output logic [LEN_W-1:0]   o_glen,
    output logic [SVC_W-1:0]   o_svc,
    output logic [TOTO_W-1:0]  o_total,
    output logic               o_ovl
);

    // Queue state
    logic [PTR_W-1:0] r_head [NUM_QUEUES];
    logic [PTR_W-1:0] r_tail [NUM_QUEUES];
    logic [CNT_W-1:0] r_cnt  [NUM_QUEUES];
    logic [TOT_W-1:0] r_total;
    logic [ID_W-1:0]  r_next_id;
    logic             r_ovl;

    // Latched item
    t_action           r_action;
    logic [QSEL_W-1:0] r_sel;
    logic [LEN_W-1:0]  r_len;
    logic              r_fault;

    // Entry memory
    logic [ENTRY_W-1:0] r_mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] r_rd;

    // Result under construction
    t_event            r_ev;
    logic [QSEL_W-1:0] r_gq;
    logic [ID_W-1:0]   r_id;
    logic [LEN_W-1:0]  r_glen;
    logic [SVC_W-1:0]  r_svc;

    // Divider
    logic [SUM_W-1:0]  r_num;
    logic [SPD_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;

    // Output register
    logic              r_out_valid;
    t_event            r_o_ev;
    logic [QSEL_W-1:0] r_o_gq;
    logic [ID_W-1:0]   r_o_id;
    logic [LEN_W-1:0]  r_o_glen;
    logic [SVC_W-1:0]  r_o_svc;
    logic [TOTO_W-1:0] r_o_total;
    logic              r_o_ovl;

    // Decision signals
    logic [QSEL_W-1:0] w_best;
    logic              w_any;
    logic              w_full;
    t_event            w_ev;
    logic              w_take_id;
    logic              w_write;
    logic              w_pop;
    logic              w_set_ovl;
    logic              w_clr_ovl;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [SUM_W-1:0]  w_trial;
    logic              w_ge;
    logic [SUM_W-1:0]  w_diff;

    // Longest queue, lower index wins ties
    always_comb begin
        w_best = '0;
        for (int q = 1; q < NUM_QUEUES; q++) begin
            if (r_cnt[q] > r_cnt[w_best]) w_best = QSEL_W'(q);
        end
    end

    assign w_any  = (r_total != '0);
    assign w_full = (r_cnt[r_sel] == CNT_W'(QUEUE_DEPTH));

    // Admission and grant decision
    always_comb begin
        w_ev      = EV_EMPTY;
        w_take_id = 1'b0;
        w_write   = 1'b0;
        w_pop     = 1'b0;
        w_set_ovl = 1'b0;
        w_clr_ovl = 1'b0;
        if (r_action == ACT_ARRIVE) begin
            priority if (r_ovl && w_any) begin
                w_ev = EV_REFUSED;
            end else if (!r_ovl && (32'(r_total) > 32'(i_limit))) begin
                w_ev      = EV_ENTER;
                w_set_ovl = 1'b1;
            end else if (r_ovl) begin
                w_ev      = EV_CLEAR;
                w_clr_ovl = 1'b1;
            end else begin
                w_take_id = 1'b1;
                w_write   = !w_full;
                w_ev      = w_full ? EV_FULL : EV_ADMIT;
            end
        end else if (w_any) begin
            w_ev  = EV_GRANT;
            w_pop = 1'b1;
        end
    end

    assign w_waddr = ADDR_W'(r_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_tail[r_sel]);
    assign w_raddr = ADDR_W'(w_best) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[w_best]);

    // Divider step: shift in next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_num[SUM_W-1]};
    assign w_ge    = (w_trial >= SUM_W'(i_speed));
    assign w_diff  = w_trial - SUM_W'(i_speed);

    // Status
    assign o_status.to_grant = (r_action == ACT_SERVE) && w_any;
    assign o_status.div_last = (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_tail[q] <= '0;
                r_cnt[q]  <= '0;
            end
            r_total   <= '0;
            r_next_id <= '0;
            r_ovl     <= 1'b0;
        end else if (i_cmd.exec) begin
            if (w_set_ovl) r_ovl <= 1'b1;
            if (w_clr_ovl) r_ovl <= 1'b0;
            if (w_take_id) r_next_id <= r_next_id + 1'b1;
            if (w_write) begin
                r_tail[r_sel] <= (r_tail[r_sel] == PTR_W'(QUEUE_DEPTH - 1))
                                 ? '0 : r_tail[r_sel] + 1'b1;
                r_cnt[r_sel]  <= r_cnt[r_sel] + 1'b1;
                r_total       <= r_total + 1'b1;
            end
            if (w_pop) begin
                r_head[w_best] <= (r_head[w_best] == PTR_W'(QUEUE_DEPTH - 1))
                                  ? '0 : r_head[w_best] + 1'b1;
                r_cnt[w_best]  <= r_cnt[w_best] - 1'b1;
                r_total        <= r_total - 1'b1;
            end
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_write && i_cmd.exec) r_mem[w_waddr] <= {r_next_id, r_len};
        if (i_cmd.exec) r_rd <= r_mem[w_raddr];
    end

    // Item latch, result fields and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_sel    <= i_sel;
            r_len    <= i_len;
            r_fault  <= i_fault;
        end
        if (i_cmd.exec) begin
            r_ev   <= w_ev;
            r_gq   <= w_take_id ? r_sel : (w_pop ? w_best : '0);
            r_id   <= w_take_id ? r_next_id : '0;
            r_glen <= '0;
            r_svc  <= '0;
        end
        if (i_cmd.rd_take) begin
            r_id   <= r_rd[ENTRY_W-1:LEN_W];
            r_glen <= r_rd[LEN_W-1:0];
            r_num  <= SUM_W'(r_rd[LEN_W-1:0]) + SUM_W'(i_path);
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[SPD_W-1:0] : w_trial[SPD_W-1:0];
            r_num  <= {r_num[SUM_W-2:0], w_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.finish) begin
            if (i_speed == '0) begin
                r_svc <= SVC_MAX;
            end else begin
                r_svc <= SVC_W'(r_num) + (r_fault ? SVC_W'(i_penalty) : '0);
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_ev    <= r_ev;
            r_o_gq    <= r_gq;
            r_o_id    <= r_id;
            r_o_glen  <= r_glen;
            r_o_svc   <= r_svc;
            r_o_total <= TOTO_W'(r_total);
            r_o_ovl   <= r_ovl;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ev        = r_o_ev;
    assign o_gq        = r_o_gq;
    assign o_id        = r_o_id;
    assign o_glen      = r_o_glen;
    assign o_svc       = r_o_svc;
    assign o_total     = r_o_total;
    assign o_ovl       = r_o_ovl;

endmodule

// File: sv/longest_queue_arbiter_with_overload_top.sv
// ============================================================================
// longest_queue_arbiter_with_overload_top
// Four-queue longest-queue-first arbiter with overload admission control.
// ============================================================================
// Takes one transaction at a time. An arrival, or a serve with nothing
// waiting, goes through the decide step and then the output register; a
// grant goes through decide, one head-entry memory read, an 11-step restoring
// divider for the service time, a finishing add, then the output register.
// The output register lets a finished result wait while the next item is
// accepted. Configuration registers are written through the cfg channel,
// which is always ready; write them only while the block is idle.
// ============================================================================
module longest_queue_arbiter_with_overload_top
    import lqa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [1:0] queue_select, [11:2] item_length, [12] fault_flag, [15:13] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] action
    input  logic                 i_s_axis_tuser,
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [1:0] granted_queue, [17:2] item_id, [27:18] granted_length,
    // [39:28] service_time, [46:40] total_waiting, [47] overload_active
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] event_code
    output logic [EV_W-1:0]      o_m_axis_tuser,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [LIM_W-1:0] r_limit;
    logic [LEN_W-1:0] r_path;
    logic [SPD_W-1:0] r_speed;
    logic [PEN_W-1:0] r_penalty;

    t_cmd              w_cmd;
    t_status           w_status;
    t_event            w_ev;
    logic [QSEL_W-1:0] w_gq;
    logic [ID_W-1:0]   w_id;
    logic [LEN_W-1:0]  w_glen;
    logic [SVC_W-1:0]  w_svc;
    logic [TOTO_W-1:0] w_total;
    logic              w_ovl;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RST;
            r_path    <= PATH_RST;
            r_speed   <= SPEED_RST;
            r_penalty <= PENALTY_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LIMIT:   r_limit   <= i_cfg_data[LIM_W-1:0];
                CFG_PATH:    r_path    <= i_cfg_data[LEN_W-1:0];
                CFG_SPEED:   r_speed   <= i_cfg_data[SPD_W-1:0];
                CFG_PENALTY: r_penalty <= i_cfg_data[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    lqa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    lqa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_action    (t_action'(i_s_axis_tuser)),
        .i_sel       (i_s_axis_tdata[1:0]),
        .i_len       (i_s_axis_tdata[11:2]),
        .i_fault     (i_s_axis_tdata[12]),
        .i_limit     (r_limit),
        .i_path      (r_path),
        .i_speed     (r_speed),
        .i_penalty   (r_penalty),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_ev        (w_ev),
        .o_gq        (w_gq),
        .o_id        (w_id),
        .o_glen      (w_glen),
        .o_svc       (w_svc),
        .o_total     (w_total),
        .o_ovl       (w_ovl)
    );

    // Result packing
    assign o_m_axis_tuser = w_ev;
    assign o_m_axis_tdata = {w_ovl, w_total, w_svc, w_glen, w_id, w_gq};

endmodule
